// ----- design/mts_pkg.sv -----
// ----------------------------------------------------------------------------
// Minimum-tracking stack package
// Widths, depth, codes and constants shared by the stack core and its
// channel interfaces.
// ----------------------------------------------------------------------------
package mts_pkg;

    // Stack geometry.
    localparam int DEPTH  = 64;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;

    // Fixed field widths of the result beat.
    localparam int STATUS_W = 2;
    localparam int FILL_W   = 7;

    // Operation codes carried in the action field.
    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_POP  = 1'b1;

    // Status codes of a result beat.
    localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_PUSH_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_POP_EMPTY  = 2'd2;

    // Minimum reported while the stack is empty (largest signed value).
    localparam logic signed [DATA_W-1:0] EMPTY_MIN = 32'sh7FFF_FFFF;

endpackage

// ----- design/mts_req_if.sv -----
// ----------------------------------------------------------------------------
// Minimum-tracking stack request channel
// Valid/ready channel that carries one push or pop operation per beat.
// ----------------------------------------------------------------------------
interface mts_req_if
    import mts_pkg::*;
();

    logic                     valid;
    logic                     ready;
    logic                     action;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);

endinterface

// ----- design/mts_rsp_if.sv -----
// ----------------------------------------------------------------------------
// Minimum-tracking stack result channel
// Valid/ready channel that carries one result beat per operation.
// ----------------------------------------------------------------------------
interface mts_rsp_if
    import mts_pkg::*;
();

    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] popped_value;
    logic signed [DATA_W-1:0] top_value;
    logic signed [DATA_W-1:0] min_value;
    logic [FILL_W-1:0]        fill_count;
    logic                     is_empty;

    modport source (output valid, output status, output popped_value, output top_value,
                    output min_value, output fill_count, output is_empty, input ready);
    modport sink   (input valid, input status, input popped_value, input top_value,
                    input min_value, input fill_count, input is_empty, output ready);

endinterface

// ----- design/mts_ram.sv -----
// ----------------------------------------------------------------------------
// Minimum-tracking stack storage RAM
// Simple dual-port synchronous RAM: one write port, one read port with a
// registered read data output.
// ----------------------------------------------------------------------------
module mts_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/min_tracking_stack_core.sv -----
// ----------------------------------------------------------------------------
// Minimum-tracking stack core
// LIFO stack of signed 32-bit values that also reports its running minimum.
//
// Usage:
//   - req carries one operation per beat: action push (with value) or pop.
//   - rsp returns exactly one result beat per operation: status, the popped
//     value, and the top, minimum and fill count after the operation.
//   - A push, a push onto a full stack and a pop of an empty stack give a
//     result that is valid in the cycle after the request beat.
//   - An accepted pop passes through ST_POP_RD, waiting on the registered read
//     of the value and minimum RAMs that supply the new top and minimum.
//   - One operation is in flight at a time; a new request beat is taken in
//     the cycle its predecessor's result beat leaves, so while rsp is not
//     stalled pushes sustain one beat per cycle; a pop holds req until it ends.
//   - While the receiver stalls rsp, the result holds and req is not ready.
//   - Reset empties both stacks at once (counts cleared, minimum set to the
//     largest signed value); the RAM contents need no clearing.
// ----------------------------------------------------------------------------
module min_tracking_stack_core
    import mts_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    mts_req_if.sink    req,
    mts_rsp_if.source  rsp
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_POP_RD = 2'd1;

    // Control state.
    logic [1:0]               state_reg, state_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [CNT_W-1:0]         min_count_reg, min_count_next;
    logic signed [DATA_W-1:0] top_reg, top_next;
    logic signed [DATA_W-1:0] min_reg, min_next;
    logic                     min_pop_reg, min_pop_next;

    // Result beat.
    logic                     out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]      status_reg, status_next;
    logic signed [DATA_W-1:0] popped_reg, popped_next;

    // RAM ports.
    logic                     val_we, min_we;
    logic [ADDR_W-1:0]        val_waddr, min_waddr;
    logic [ADDR_W-1:0]        val_raddr, min_raddr;
    logic [DATA_W-1:0]        val_rdata, min_rdata;
    logic [CNT_W-1:0]         val_rd_cnt, min_rd_cnt;

    logic                     accept;
    logic                     full, empty, to_min;

    mts_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_value_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr (val_waddr),
        .wdata (req.value),
        .raddr (val_raddr),
        .rdata (val_rdata)
    );

    mts_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_min_ram (
        .clk   (clk),
        .we    (min_we),
        .waddr (min_waddr),
        .wdata (req.value),
        .raddr (min_raddr),
        .rdata (min_rdata)
    );

    // A new beat is taken when idle and the result slot is free or draining.
    assign req.ready = (state_reg == ST_IDLE) && (!out_valid_reg || rsp.ready);
    assign accept    = req.valid && req.ready;

    assign full   = (count_reg == CNT_W'(DEPTH));
    assign empty  = (count_reg == '0);
    assign to_min = (req.value <= min_reg);

    // Write addresses are the current counts; reads fetch the entry below
    // the one being popped, which becomes the new top.
    assign val_waddr  = count_reg[ADDR_W-1:0];
    assign min_waddr  = min_count_reg[ADDR_W-1:0];
    assign val_rd_cnt = count_reg - CNT_W'(2);
    assign min_rd_cnt = min_count_reg - CNT_W'(2);
    assign val_raddr  = val_rd_cnt[ADDR_W-1:0];
    assign min_raddr  = min_rd_cnt[ADDR_W-1:0];

    assign val_we = accept && (req.action == ACT_PUSH) && !full;
    assign min_we = val_we && to_min && (min_count_reg != CNT_W'(DEPTH));

    // Operation sequencing and state update.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        min_count_next = min_count_reg;
        top_next       = top_reg;
        min_next       = min_reg;
        min_pop_next   = min_pop_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        popped_next    = popped_reg;

        if (rsp.valid && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    popped_next = '0;
                    if (req.action == ACT_PUSH)
                    begin
                        out_valid_next = 1'b1;
                        if (full)
                        begin
                            status_next = STATUS_PUSH_FULL;
                        end
                        else
                        begin
                            status_next = STATUS_OK;
                            count_next  = count_reg + CNT_W'(1);
                            top_next    = req.value;
                            if (min_we)
                            begin
                                min_count_next = min_count_reg + CNT_W'(1);
                                min_next       = req.value;
                            end
                        end
                    end
                    else if (empty)
                    begin
                        out_valid_next = 1'b1;
                        status_next    = STATUS_POP_EMPTY;
                    end
                    else
                    begin
                        // Pop: counts drop now, top and minimum follow the read.
                        status_next  = STATUS_OK;
                        popped_next  = top_reg;
                        count_next   = count_reg - CNT_W'(1);
                        min_pop_next = (min_count_reg != '0) && (top_reg == min_reg);
                        if ((min_count_reg != '0) && (top_reg == min_reg))
                        begin
                            min_count_next = min_count_reg - CNT_W'(1);
                        end
                        state_next = ST_POP_RD;
                    end
                end
            end
            ST_POP_RD:
            begin
                top_next = (count_reg == '0) ? '0 : $signed(val_rdata);
                if (min_pop_reg)
                begin
                    min_next = (min_count_reg == '0) ? EMPTY_MIN : $signed(min_rdata);
                end
                out_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and stack state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            min_count_reg <= '0;
            top_reg       <= '0;
            min_reg       <= EMPTY_MIN;
            min_pop_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            min_count_reg <= min_count_next;
            top_reg       <= top_next;
            min_reg       <= min_next;
            min_pop_reg   <= min_pop_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload registers.
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        popped_reg <= popped_next;
    end

    // The stack state cannot move while a result waits, so the top, minimum
    // and fill count of the pending beat are read straight from it.
    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = status_reg;
    assign rsp.popped_value = popped_reg;
    assign rsp.top_value    = top_reg;
    assign rsp.min_value    = min_reg;
    assign rsp.fill_count   = FILL_W'(count_reg);
    assign rsp.is_empty     = (count_reg == '0);

endmodule
